// ===== sv/load_level_storage_sequencer_macros.svh =====
// Assertion helpers used by the checker of the load-level storage sequencer.
`ifndef LOAD_LEVEL_STORAGE_SEQUENCER_MACROS_SVH
`define LOAD_LEVEL_STORAGE_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define LLSS_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define LLSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/llss_pkg.sv =====
package llss_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_UP_END  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_END     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_END    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ENDSTOP      = 3'd6;

   // Field widths
   localparam int MW_W    = 16;
   localparam int MM_W    = 16;
   localparam int SHORT_W = 16;
   localparam int MS_W    = 20;
   localparam int NOW_W   = 32;
   localparam int DUTY_W  = 7;
   localparam int GRID_W  = 2;

   // Grid state codes
   localparam logic [GRID_W-1:0] GRID_LIGHT    = 2'd0;
   localparam logic [GRID_W-1:0] GRID_STABLE   = 2'd1;
   localparam logic [GRID_W-1:0] GRID_OVERLOAD = 2'd2;

   // Duty constants
   localparam logic [DUTY_W-1:0] PCT_FULL         = 7'd100;
   localparam logic [DUTY_W-1:0] RELEASE_DUTY     = 7'd40;
   localparam logic [DUTY_W-1:0] DESCENT_MIN_DUTY = 7'd30;
   localparam int                LIGHT_SPAN       = 50;

   // x*70/100 for x <= 100 as (x * 367010) >> 19
   localparam int                DESCENT_SHIFT  = 19;
   localparam int                DESCENT_PROD_W = 26;
   localparam logic [18:0]       DESCENT_RECIP  = 19'd367010;

   // Register reset values
   localparam logic [MW_W-1:0]    LIGHT_LIMIT_RST  = 16'd1000;
   localparam logic [MW_W-1:0]    STABLE_LIMIT_RST = 16'd1200;
   localparam logic [SHORT_W-1:0] RELEASE_RST      = 16'd1500;
   localparam logic [MS_W-1:0]    RAMP_UP_END_RST  = 20'd30000;
   localparam logic [MS_W-1:0]    HOLD_END_RST     = 20'd75000;
   localparam logic [MS_W-1:0]    CYCLE_END_RST    = 20'd105000;
   localparam logic [MM_W-1:0]    ENDSTOP_RST      = 16'd200;

   // Shared divider: every quotient it serves stays below 128
   localparam int DIV_NUM_W = 27;
   localparam int DIV_DEN_W = 20;
   localparam int QUOT_W    = 7;
   localparam int DIV_CNT_W = 3;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } llss_div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } llss_div_rsp_type;

endpackage

// ===== sv/load_level_storage_sequencer.sv =====
// Load-level storage sequencer: one request item per control tick (timestamp, load
// power, top and bottom end-stop distances) yields one response item with grid state,
// motor duty and direction, dissipation duty, latch command and a servo strobe that
// fires when the latch command changes. Power below light_limit_mw lifts the weight at
// 100 down toward 50 percent; up to stable_limit_mw everything stops; above that an
// overload cycle runs: a release lift at 40 percent with the latch open, then a
// dissipation ramp, hold and fall while the weight is lowered at 30 plus 70 percent of
// the dissipation duty until the bottom end-stop locks the latch. The cycle restarts
// once the time past the release exceeds cycle_end_ms. The longest paths wait on one
// shared divider that resolves one of seven quotient bits per cycle. req_ready is high
// only between items; a finished item sits in the response register while the next one
// is already taken and worked on.
// The configuration port is always ready; write it only while the block is idle.
module load_level_storage_sequencer
   import llss_pkg::*;
#(
   parameter int TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [NOW_W-1:0]      req_now_ms,
   input  logic [MW_W-1:0]       req_power_mw,
   input  logic [MM_W-1:0]       req_top_distance_mm,
   input  logic [MM_W-1:0]       req_bottom_distance_mm,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [GRID_W-1:0]     rsp_grid_state,
   output logic [DUTY_W-1:0]     rsp_motor_duty,
   output logic                  rsp_motor_up,
   output logic [DUTY_W-1:0]     rsp_dissipation_duty,
   output logic                  rsp_latch_open,
   output logic                  rsp_latch_changed,
   // Configuration port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Compare width covers both cycle times and the 20-bit schedule registers
   localparam int CmpW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

   typedef enum logic [2:0] {
      S_IDLE, S_CLASS, S_TIME, S_CURVE, S_DIV, S_POST, S_DESC, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_LIGHT, OP_RISE, OP_FALL
   } div_op_type;

   // Configuration registers
   logic [MW_W-1:0]    light_limit_ff;
   logic [MW_W-1:0]    stable_limit_ff;
   logic [SHORT_W-1:0] release_ff;
   logic [MS_W-1:0]    ramp_up_end_ff;
   logic [MS_W-1:0]    hold_end_ff;
   logic [MS_W-1:0]    cycle_end_ff;
   logic [MM_W-1:0]    endstop_ff;

   // Sequencer and persistent state
   state_type              state_ff, state_in;
   div_op_type             op_ff, op_in;
   logic                   in_cycle_ff, in_cycle_in;
   logic                   descent_ff, descent_in;
   logic                   latch_pos_ff, latch_pos_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;

   // Captured item and working values
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [MW_W-1:0]        power_ff, power_in;
   logic                   top_hit_ff, top_hit_in;
   logic                   bot_hit_ff, bot_hit_in;
   logic [GRID_W-1:0]      mode_ff, mode_in;
   logic [CmpW-1:0]        t_ff, t_in;
   logic [DUTY_W-1:0]      motor_ff, motor_in;
   logic [DUTY_W-1:0]      diss_ff, diss_in;
   logic                   up_ff, up_in;
   logic                   open_ff, open_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GRID_W-1:0]      rsp_grid_ff, rsp_grid_in;
   logic [DUTY_W-1:0]      rsp_motor_ff, rsp_motor_in;
   logic                   rsp_up_ff, rsp_up_in;
   logic [DUTY_W-1:0]      rsp_diss_ff, rsp_diss_in;
   logic                   rsp_open_ff, rsp_open_in;
   logic                   rsp_changed_ff, rsp_changed_in;

   // Divider hookup
   llss_div_req_type       div_req_ff, div_req_in;
   llss_div_rsp_type       div_rsp;

   logic [TIME_BITS-1:0]   elapsed;
   logic [CmpW-1:0]        fall_off;
   logic [DESCENT_PROD_W-1:0] descent_prod;

   llss_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign elapsed      = now_ff - start_ff;
   assign fall_off     = t_ff - CmpW'(hold_end_ff);
   assign descent_prod = DESCENT_PROD_W'(diss_ff) * DESCENT_PROD_W'(DESCENT_RECIP);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      in_cycle_in    = in_cycle_ff;
      descent_in     = descent_ff;
      latch_pos_in   = latch_pos_ff;
      start_in       = start_ff;
      now_in         = now_ff;
      power_in       = power_ff;
      top_hit_in     = top_hit_ff;
      bot_hit_in     = bot_hit_ff;
      mode_in        = mode_ff;
      t_in           = t_ff;
      motor_in       = motor_ff;
      diss_in        = diss_ff;
      up_in          = up_ff;
      open_in        = open_ff;
      div_req_in     = div_req_ff;
      div_req_in.start = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      rsp_grid_in    = rsp_grid_ff;
      rsp_motor_in   = rsp_motor_ff;
      rsp_up_in      = rsp_up_ff;
      rsp_diss_in    = rsp_diss_ff;
      rsp_open_in    = rsp_open_ff;
      rsp_changed_in = rsp_changed_ff;

      // Drop the response once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            // Capture the item; end-stop tests happen right here
            if (req_valid) begin
               now_in     = TIME_BITS'(req_now_ms);
               power_in   = req_power_mw;
               top_hit_in = (req_top_distance_mm != '0) &&
                            (req_top_distance_mm <= endstop_ff);
               bot_hit_in = (req_bottom_distance_mm != '0) &&
                            (req_bottom_distance_mm <= endstop_ff);
               state_in   = S_CLASS;
            end
         end
         S_CLASS: begin
            motor_in = '0;
            diss_in  = '0;
            up_in    = 1'b1;
            open_in  = 1'b0;
            // Light test first, then stable; inverted limits follow that order
            if (power_ff < light_limit_ff) begin
               mode_in        = GRID_LIGHT;
               in_cycle_in    = 1'b0;
               descent_in     = 1'b0;
               op_in          = OP_LIGHT;
               div_req_in.start = 1'b1;
               div_req_in.num = DIV_NUM_W'(power_ff) * DIV_NUM_W'(LIGHT_SPAN);
               div_req_in.den = DIV_DEN_W'(light_limit_ff);
               state_in       = S_DIV;
            end else if (power_ff <= stable_limit_ff) begin
               mode_in     = GRID_STABLE;
               in_cycle_in = 1'b0;
               descent_in  = 1'b0;
               up_in       = 1'b0;
               state_in    = S_OUT;
            end else begin
               mode_in = GRID_OVERLOAD;
               open_in = 1'b1;
               // Entering overload starts a fresh cycle at this tick
               if (!in_cycle_ff) begin
                  in_cycle_in = 1'b1;
                  descent_in  = 1'b0;
                  start_in    = now_ff;
               end
               state_in = S_TIME;
            end
         end
         S_TIME: begin
            if (CmpW'(elapsed) <= CmpW'(release_ff)) begin
               motor_in = RELEASE_DUTY;
               state_in = S_OUT;
            end else begin
               t_in     = CmpW'(elapsed) - CmpW'(release_ff);
               state_in = S_CURVE;
            end
         end
         S_CURVE: begin
            // Past the fall: restart the cycle, but this tick still uses t
            if (t_ff > CmpW'(cycle_end_ff)) begin
               start_in   = now_ff;
               descent_in = 1'b0;
            end
            if (t_ff <= CmpW'(ramp_up_end_ff)) begin
               if (ramp_up_end_ff == '0) begin
                  diss_in  = '0;
                  state_in = S_DESC;
               end else begin
                  op_in            = OP_RISE;
                  div_req_in.start = 1'b1;
                  div_req_in.num   = DIV_NUM_W'(t_ff[MS_W-1:0]) * DIV_NUM_W'(PCT_FULL);
                  div_req_in.den   = ramp_up_end_ff;
                  state_in         = S_DIV;
               end
            end else if (t_ff <= CmpW'(hold_end_ff)) begin
               diss_in  = PCT_FULL;
               state_in = S_DESC;
            end else if (t_ff >= CmpW'(cycle_end_ff)) begin
               diss_in  = '0;
               state_in = S_DESC;
            end else begin
               op_in            = OP_FALL;
               div_req_in.start = 1'b1;
               div_req_in.num   = DIV_NUM_W'(fall_off[MS_W-1:0]) * DIV_NUM_W'(PCT_FULL);
               div_req_in.den   = cycle_end_ff - hold_end_ff;
               state_in         = S_DIV;
            end
         end
         S_DIV: begin
            // Hold until the shared divider reports its quotient
            if (div_rsp.done) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            case (op_ff)
               OP_LIGHT: begin
                  motor_in = top_hit_ff ? '0 : (PCT_FULL - div_rsp.quot);
                  state_in = S_OUT;
               end
               OP_RISE: begin
                  diss_in  = div_rsp.quot;
                  state_in = S_DESC;
               end
               OP_FALL: begin
                  diss_in  = PCT_FULL - div_rsp.quot;
                  state_in = S_DESC;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_DESC: begin
            // Dissipation never exceeds 100 here, so the duty stays within 100
            if (!descent_ff) begin
               up_in = 1'b0;
               if (bot_hit_ff) begin
                  motor_in   = '0;
                  open_in    = 1'b0;
                  descent_in = 1'b1;
               end else begin
                  motor_in = DESCENT_MIN_DUTY +
                             descent_prod[DESCENT_PROD_W-1:DESCENT_SHIFT];
               end
            end else begin
               motor_in = '0;
               open_in  = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Load the response register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_grid_in    = mode_ff;
               rsp_motor_in   = motor_ff;
               rsp_up_in      = up_ff;
               rsp_diss_in    = diss_ff;
               rsp_open_in    = open_ff;
               rsp_changed_in = (open_ff != latch_pos_ff);
               latch_pos_in   = open_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         in_cycle_ff      <= 1'b0;
         descent_ff       <= 1'b0;
         latch_pos_ff     <= 1'b0;
         start_ff         <= '0;
         mode_ff          <= GRID_LIGHT;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
         light_limit_ff   <= LIGHT_LIMIT_RST;
         stable_limit_ff  <= STABLE_LIMIT_RST;
         release_ff       <= RELEASE_RST;
         ramp_up_end_ff   <= RAMP_UP_END_RST;
         hold_end_ff      <= HOLD_END_RST;
         cycle_end_ff     <= CYCLE_END_RST;
         endstop_ff       <= ENDSTOP_RST;
      end else begin
         state_ff         <= state_in;
         in_cycle_ff      <= in_cycle_in;
         descent_ff       <= descent_in;
         latch_pos_ff     <= latch_pos_in;
         start_ff         <= start_in;
         mode_ff          <= mode_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_req_ff.start <= div_req_in.start;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LIGHT_LIMIT:  light_limit_ff  <= csr_data[MW_W-1:0];
               CSR_STABLE_LIMIT: stable_limit_ff <= csr_data[MW_W-1:0];
               CSR_RELEASE:      release_ff      <= csr_data[SHORT_W-1:0];
               CSR_RAMP_UP_END:  ramp_up_end_ff  <= csr_data[MS_W-1:0];
               CSR_HOLD_END:     hold_end_ff     <= csr_data[MS_W-1:0];
               CSR_CYCLE_END:    cycle_end_ff    <= csr_data[MS_W-1:0];
               CSR_ENDSTOP:      endstop_ff      <= csr_data[MM_W-1:0];
               default: begin
               end
            endcase
         end
      end
      op_ff          <= op_in;
      now_ff         <= now_in;
      power_ff       <= power_in;
      top_hit_ff     <= top_hit_in;
      bot_hit_ff     <= bot_hit_in;
      t_ff           <= t_in;
      motor_ff       <= motor_in;
      diss_ff        <= diss_in;
      up_ff          <= up_in;
      open_ff        <= open_in;
      div_req_ff.num <= div_req_in.num;
      div_req_ff.den <= div_req_in.den;
      rsp_grid_ff    <= rsp_grid_in;
      rsp_motor_ff   <= rsp_motor_in;
      rsp_up_ff      <= rsp_up_in;
      rsp_diss_ff    <= rsp_diss_in;
      rsp_open_ff    <= rsp_open_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_grid_state       = rsp_grid_ff;
   assign rsp_motor_duty       = rsp_motor_ff;
   assign rsp_motor_up         = rsp_up_ff;
   assign rsp_dissipation_duty = rsp_diss_ff;
   assign rsp_latch_open       = rsp_open_ff;
   assign rsp_latch_changed    = rsp_changed_ff;

endmodule

// ===== sv/llss_div.sv =====
module llss_div
   import llss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  llss_div_req_type div_req,
   output llss_div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] dsh_ff, dsh_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic                 fits;

   // One quotient bit per cycle, most significant first
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      fits    = (rem_ff >= dsh_ff);
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(QUOT_W - 1);
         rem_in  = div_req.num;
         dsh_in  = DIV_NUM_W'(div_req.den) << (QUOT_W - 1);
         quot_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ===== sv/llss_checker.sv =====
`include "load_level_storage_sequencer_macros.svh"

module llss_checker
   import llss_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [GRID_W-1:0] rsp_grid_state,
   input logic [DUTY_W-1:0] rsp_motor_duty,
   input logic              rsp_motor_up,
   input logic [DUTY_W-1:0] rsp_dissipation_duty,
   input logic              rsp_latch_open,
   input logic              rsp_latch_changed
);

   logic last_open_ff, last_open_in;

   // Track the latch command of the last delivered item
   always_comb begin
      last_open_in = last_open_ff;
      if (rsp_valid && rsp_ready) begin
         last_open_in = rsp_latch_open;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_open_ff <= 1'b0;
      end else begin
         last_open_ff <= last_open_in;
      end
   end

   `LLSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_motor_duty) && $stable(rsp_latch_open) && $stable(rsp_grid_state), "response changed while stalled")
   `LLSS_ASSERT(a_rsp_range, rsp_valid, (rsp_motor_duty <= PCT_FULL) && (rsp_dissipation_duty <= PCT_FULL) && (rsp_grid_state <= GRID_OVERLOAD), "response field out of range")
   `LLSS_ASSERT(a_stable_stop, rsp_valid && (rsp_grid_state == GRID_STABLE), (rsp_motor_duty == '0) && !rsp_motor_up && (rsp_dissipation_duty == '0) && !rsp_latch_open, "stable state not at rest")
   `LLSS_ASSERT(a_light_lock, rsp_valid && (rsp_grid_state == GRID_LIGHT), !rsp_latch_open && rsp_motor_up && (rsp_dissipation_duty == '0), "light state not lifting with latch locked")
   `LLSS_ASSERT(a_latch_strobe, rsp_valid, rsp_latch_changed == (rsp_latch_open != last_open_ff), "latch strobe disagrees with latch history")

endmodule

bind load_level_storage_sequencer llss_checker u_llss_checker (.*);

// ===== bench/tb_load_level_storage_sequencer.sv =====
`timescale 1ns / 100ps

module tb_load_level_storage_sequencer;
   import llss_pkg::*;

   // Lowering duty spans 30..100 percent, i.e. 70 points over full dissipation.
   localparam int DESCENT_SPAN_PCT = 70;
   // Cycles to let pass after the last result before touching registers or ending.
   localparam int SETTLE_CYCLES    = 40;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [GRID_W-1:0] grid_state;
      logic [DUTY_W-1:0] motor_duty;
      logic              motor_up;
      logic [DUTY_W-1:0] dissipation_duty;
      logic              latch_open;
      logic              latch_changed;
   } level_result_type;

   // Ports of the block
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [NOW_W-1:0]      req_now_ms;
   logic [MW_W-1:0]       req_power_mw;
   logic [MM_W-1:0]       req_top_distance_mm;
   logic [MM_W-1:0]       req_bottom_distance_mm;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [GRID_W-1:0]     rsp_grid_state;
   logic [DUTY_W-1:0]     rsp_motor_duty;
   logic                  rsp_motor_up;
   logic [DUTY_W-1:0]     rsp_dissipation_duty;
   logic                  rsp_latch_open;
   logic                  rsp_latch_changed;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Register copy, tracked from accepted writes
   logic [MW_W-1:0]    cfg_light_limit  = LIGHT_LIMIT_RST;
   logic [MW_W-1:0]    cfg_stable_limit = STABLE_LIMIT_RST;
   logic [SHORT_W-1:0] cfg_release      = RELEASE_RST;
   logic [MS_W-1:0]    cfg_ramp_up_end  = RAMP_UP_END_RST;
   logic [MS_W-1:0]    cfg_hold_end     = HOLD_END_RST;
   logic [MS_W-1:0]    cfg_cycle_end    = CYCLE_END_RST;
   logic [MM_W-1:0]    cfg_endstop      = ENDSTOP_RST;

   // Sequencer state as the predictor sees it
   logic [GRID_W-1:0] ps_grid         = GRID_LIGHT;
   logic              ps_in_cycle     = 1'b0;
   logic [NOW_W-1:0]  ps_cycle_start  = '0;
   logic              ps_descent_done = 1'b0;
   logic              ps_latch        = 1'b0;

   level_result_type expected_levels_q[$];

   // Stimulus shaping
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   logic [NOW_W-1:0] tick_now_ms;
   int unsigned      tick_step_ms;
   logic [GRID_W-1:0] power_class;
   int unsigned      class_left;

   // Run statistics
   int mismatch_count;
   int ticks_sent;
   int settings_count;
   int light_seen, stable_seen, overload_seen, latch_moves;

   load_level_storage_sequencer uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_now_ms             (req_now_ms),
      .req_power_mw           (req_power_mw),
      .req_top_distance_mm    (req_top_distance_mm),
      .req_bottom_distance_mm (req_bottom_distance_mm),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_grid_state         (rsp_grid_state),
      .rsp_motor_duty         (rsp_motor_duty),
      .rsp_motor_up           (rsp_motor_up),
      .rsp_dissipation_duty   (rsp_dissipation_duty),
      .rsp_latch_open         (rsp_latch_open),
      .rsp_latch_changed      (rsp_latch_changed),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always #5 clock = ~clock;

   // Work out one tick: classify power, advance the overload cycle, derive duties and
   // the latch strobe. Updates the predictor state in place.
   function automatic level_result_type predict_level(input logic [NOW_W-1:0] now,
                                                      input logic [MW_W-1:0]  power,
                                                      input logic [MM_W-1:0]  top_mm,
                                                      input logic [MM_W-1:0]  bottom_mm);
      level_result_type  res;
      logic [NOW_W-1:0]  elapsed;
      longint unsigned   motor, diss, t, pwr;
      logic              up, open, top_hit, bottom_hit;
      top_hit    = (top_mm != 0) && (top_mm <= cfg_endstop);
      bottom_hit = (bottom_mm != 0) && (bottom_mm <= cfg_endstop);
      motor = 0;
      diss  = 0;
      up    = 1'b1;
      open  = 1'b0;
      pwr   = 64'(power);

      // Light test first, so overlapping limits resolve toward light
      if (power < cfg_light_limit)
         ps_grid = GRID_LIGHT;
      else if (power <= cfg_stable_limit)
         ps_grid = GRID_STABLE;
      else
         ps_grid = GRID_OVERLOAD;

      case (ps_grid)
         GRID_LIGHT: begin
            ps_in_cycle     = 1'b0;
            ps_descent_done = 1'b0;
            motor = PCT_FULL - (pwr * LIGHT_SPAN) / cfg_light_limit;
            if (top_hit)
               motor = 0;
         end
         GRID_STABLE: begin
            ps_in_cycle     = 1'b0;
            ps_descent_done = 1'b0;
            up = 1'b0;
         end
         default: begin
            if (!ps_in_cycle) begin
               ps_in_cycle     = 1'b1;
               ps_descent_done = 1'b0;
               ps_cycle_start  = now;
            end
            elapsed = now - ps_cycle_start;
            open = 1'b1;
            if (elapsed <= cfg_release) begin
               motor = 64'(RELEASE_DUTY);
            end else begin
               t = 64'(elapsed) - 64'(cfg_release);
               // Restart once past the fall; this tick still uses the old t
               if (t > cfg_cycle_end) begin
                  ps_cycle_start  = now;
                  ps_descent_done = 1'b0;
               end
               if (t <= cfg_ramp_up_end)
                  diss = (cfg_ramp_up_end == 0) ? 0 : (t * PCT_FULL) / cfg_ramp_up_end;
               else if (t <= cfg_hold_end)
                  diss = 64'(PCT_FULL);
               else if (t >= cfg_cycle_end)
                  diss = 0;
               else
                  diss = PCT_FULL - ((t - cfg_hold_end) * PCT_FULL) /
                         (longint'(cfg_cycle_end) - longint'(cfg_hold_end));
               if (diss > PCT_FULL)
                  diss = 64'(PCT_FULL);
               if (!ps_descent_done) begin
                  up = 1'b0;
                  motor = DESCENT_MIN_DUTY + (diss * DESCENT_SPAN_PCT) / PCT_FULL;
                  if (bottom_hit) begin
                     motor           = 0;
                     open            = 1'b0;
                     ps_descent_done = 1'b1;
                  end
               end else begin
                  motor = 0;
                  open  = 1'b0;
               end
            end
         end
      endcase

      if (motor > PCT_FULL)
         motor = 64'(PCT_FULL);

      res.grid_state       = ps_grid;
      res.motor_duty       = DUTY_W'(motor);
      res.motor_up         = up;
      res.dissipation_duty = DUTY_W'(diss);
      res.latch_open       = open;
      res.latch_changed    = (open != ps_latch);
      ps_latch = open;
      return res;
   endfunction

   function automatic int unsigned draw_between(input int unsigned lo, input int unsigned hi);
      return (hi < lo) ? lo : $urandom_range(hi, lo);
   endfunction

   // Sample every handshake at the rising edge: track register writes, predict each
   // accepted item and check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      level_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LIGHT_LIMIT:  cfg_light_limit  = csr_data[MW_W-1:0];
               CSR_STABLE_LIMIT: cfg_stable_limit = csr_data[MW_W-1:0];
               CSR_RELEASE:      cfg_release      = csr_data[SHORT_W-1:0];
               CSR_RAMP_UP_END:  cfg_ramp_up_end  = csr_data[MS_W-1:0];
               CSR_HOLD_END:     cfg_hold_end     = csr_data[MS_W-1:0];
               CSR_CYCLE_END:    cfg_cycle_end    = csr_data[MS_W-1:0];
               CSR_ENDSTOP:      cfg_endstop      = csr_data[MM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = predict_level(req_now_ms, req_power_mw, req_top_distance_mm,
                                 req_bottom_distance_mm);
            expected_levels_q.push_back(want);
            ticks_sent++;
            case (want.grid_state)
               GRID_LIGHT:  light_seen++;
               GRID_STABLE: stable_seen++;
               default:     overload_seen++;
            endcase
            if (want.latch_changed)
               latch_moves++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_levels_q.size() == 0) begin
               $error("result item arrived with no tick outstanding");
               mismatch_count++;
            end else begin
               want = expected_levels_q.pop_front();
               if (rsp_grid_state !== want.grid_state) begin
                  $error("grid_state: expected %0d, got %0d", want.grid_state, rsp_grid_state);
                  mismatch_count++;
               end
               if (rsp_motor_duty !== want.motor_duty) begin
                  $error("motor_duty: expected %0d, got %0d", want.motor_duty, rsp_motor_duty);
                  mismatch_count++;
               end
               if (rsp_motor_up !== want.motor_up) begin
                  $error("motor_up: expected %0d, got %0d", want.motor_up, rsp_motor_up);
                  mismatch_count++;
               end
               if (rsp_dissipation_duty !== want.dissipation_duty) begin
                  $error("dissipation_duty: expected %0d, got %0d",
                         want.dissipation_duty, rsp_dissipation_duty);
                  mismatch_count++;
               end
               if (rsp_latch_open !== want.latch_open) begin
                  $error("latch_open: expected %0d, got %0d", want.latch_open, rsp_latch_open);
                  mismatch_count++;
               end
               if (rsp_latch_changed !== want.latch_changed) begin
                  $error("latch_changed: expected %0d, got %0d",
                         want.latch_changed, rsp_latch_changed);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Stall the result side at random, one decision per falling edge.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 85; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 85; end
         default:       begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
   endtask

   // Offer one item; hold valid and payload until the block takes it.
   task automatic send_tick(input logic [NOW_W-1:0] now, input logic [MW_W-1:0] power,
                            input logic [MM_W-1:0] top_mm, input logic [MM_W-1:0] bottom_mm);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid              = 1'b1;
      req_now_ms             = now;
      req_power_mw           = power;
      req_top_distance_mm    = top_mm;
      req_bottom_distance_mm = bottom_mm;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Drop valid and let every outstanding result drain before going on.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_levels_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // Rewrite all registers while idle and rescale the tick spacing so that an overload
   // cycle spans a few dozen ticks.
   task automatic apply_settings(input int unsigned light, input int unsigned stable,
                                 input int unsigned release_len, input int unsigned ramp,
                                 input int unsigned hold, input int unsigned cycle_len,
                                 input int unsigned endstop);
      drain_results();
      write_reg(CSR_LIGHT_LIMIT, light);
      write_reg(CSR_STABLE_LIMIT, stable);
      write_reg(CSR_RELEASE, release_len);
      write_reg(CSR_RAMP_UP_END, ramp);
      write_reg(CSR_HOLD_END, hold);
      write_reg(CSR_CYCLE_END, cycle_len);
      write_reg(CSR_ENDSTOP, endstop);
      @(negedge clock);
      csr_valid = 1'b0;
      tick_step_ms = (release_len + cycle_len) / 40;
      if (tick_step_ms == 0)
         tick_step_ms = 1;
      settings_count++;
   endtask

   // One random tick: power follows runs of one grid class (overload runs long enough to
   // cross several cycles), time mostly advances by a step, with jumps and backsteps mixed
   // in; end-stops are hit now and then.
   task automatic random_tick();
      int unsigned       r, overload_floor;
      logic [MW_W-1:0]   power;
      logic [MM_W-1:0]   top_mm, bottom_mm;
      if (class_left == 0) begin
         r = $urandom_range(99);
         power_class = (r < 50) ? GRID_OVERLOAD : (r < 75) ? GRID_LIGHT : GRID_STABLE;
         class_left = (power_class == GRID_OVERLOAD) ? $urandom_range(150, 20)
                                                     : $urandom_range(40, 1);
      end
      class_left--;

      overload_floor = int'(cfg_stable_limit) + 1;
      if (overload_floor < cfg_light_limit)
         overload_floor = int'(cfg_light_limit);
      if ($urandom_range(99) < 5)
         power = MW_W'($urandom_range(65535, 0));
      else if (power_class == GRID_LIGHT)
         power = MW_W'(draw_between(0, int'(cfg_light_limit) - 1));
      else if (power_class == GRID_STABLE)
         power = MW_W'(draw_between(int'(cfg_light_limit), int'(cfg_stable_limit)));
      else if (cfg_stable_limit == 16'hFFFF)
         power = 16'hFFFF;
      else
         power = MW_W'(draw_between(overload_floor, 65535));

      r = $urandom_range(99);
      if (r < 3)
         tick_now_ms += $urandom();
      else if (r < 6)
         tick_now_ms -= draw_between(1, tick_step_ms);
      else
         tick_now_ms += draw_between(1, tick_step_ms);

      r = $urandom_range(99);
      if (r < 25)
         top_mm = MM_W'(draw_between(1, int'(cfg_endstop)));
      else if (r < 50)
         top_mm = '0;
      else
         top_mm = MM_W'($urandom_range(65535, 0));

      r = $urandom_range(99);
      if (r < 4)
         bottom_mm = MM_W'(draw_between(1, int'(cfg_endstop)));
      else if (r < 8)
         bottom_mm = '0;
      else if (r < 20)
         bottom_mm = MM_W'($urandom_range(65535, 0));
      else
         bottom_mm = MM_W'(draw_between(int'(cfg_endstop) + 1, 65535));

      send_tick(tick_now_ms, power, top_mm, bottom_mm);
   endtask

   // Spread the random ticks over every idling pattern in turn.
   task automatic run_random_ticks(input int n);
      idle_mode_type order[4];
      order = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
      foreach (order[i]) begin
         set_idle(order[i]);
         repeat (n / 4) random_tick();
      end
   endtask

   // Walk the reset settings through every grid class, the top end-stop, a full overload
   // cycle from release lift through ramp, hold and fall, a bottom stop, the restart and
   // a cycle that starts just before the time counter wraps.
   task automatic test_directed_corners();
      set_idle(IDLE_NONE);
      send_tick(32'd0,      16'd0,     16'd0,     16'd0);
      send_tick(32'd50,     16'd999,   16'd200,   16'd0);
      send_tick(32'd100,    16'd999,   16'd201,   16'hFFFF);
      send_tick(32'd150,    16'd1000,  16'd0,     16'd0);
      send_tick(32'd200,    16'd1200,  16'hFFFF,  16'd0);
      send_tick(32'd1000,   16'd1201,  16'd0,     16'hFFFF);
      send_tick(32'd2500,   16'hFFFF,  16'd0,     16'd201);
      send_tick(32'd2501,   16'd1300,  16'd0,     16'd0);
      send_tick(32'd17500,  16'd1300,  16'd0,     16'd0);
      send_tick(32'd32500,  16'd1300,  16'd0,     16'd0);
      send_tick(32'd77500,  16'd1300,  16'd0,     16'd0);
      send_tick(32'd92500,  16'd1300,  16'd0,     16'd0);
      send_tick(32'd107499, 16'd1300,  16'd0,     16'd0);
      // bottom end-stop locks the latch and ends the descent
      send_tick(32'd107499, 16'd1300,  16'd0,     16'd200);
      send_tick(32'd107500, 16'd1300,  16'd0,     16'd0);
      // past the fall: cycle restarts on this tick
      send_tick(32'd107501, 16'd1300,  16'd0,     16'd1);
      send_tick(32'd107601, 16'd1300,  16'd0,     16'd0);
      send_tick(32'd107700, 16'd500,   16'd0,     16'd0);
      send_tick(32'hFFFF_FF00, 16'd1201, 16'd0,   16'd0);
      send_tick(32'h0000_0100, 16'd1201, 16'd0,   16'd0);
      send_tick(32'h0000_0800, 16'd1201, 16'd0,   16'd0);
      send_tick(32'h0000_0900, 16'd1100, 16'd0,   16'd0);
      tick_now_ms = 32'h0000_1000;
   endtask

   task automatic test_reset_settings();
      run_random_ticks(400);
   endtask

   task automatic test_short_cycle();
      apply_settings(1000, 1200, 20, 50, 100, 200, 200);
      run_random_ticks(300);
   endtask

   // Inverted limits: light below 1 mW, everything else overload; no end-stop ever.
   task automatic test_low_extremes();
      apply_settings(1, 0, 0, 1, 1, 2, 0);
      run_random_ticks(200);
   endtask

   task automatic test_high_extremes();
      apply_settings(65535, 65535, 65535, 1048575, 1048575, 1048575, 65535);
      run_random_ticks(100);
      apply_settings(65535, 65534, 65535, 1048575, 1048575, 1048575, 65535);
      run_random_ticks(200);
   endtask

   // Mostly ordered, compact timing so cycles complete; sometimes anything in range.
   task automatic test_random_settings();
      int unsigned light, stable, release_len, ramp, hold, cycle_len, endstop;
      repeat (4) begin
         light       = draw_between(200, 3000);
         stable      = light + $urandom_range(1500, 0);
         release_len = $urandom_range(2000, 0);
         ramp        = $urandom_range(5000, 1);
         hold        = ramp + $urandom_range(5000, 0);
         cycle_len   = hold + $urandom_range(5000, 1);
         endstop     = $urandom_range(400, 0);
         if ($urandom_range(3) == 0) begin
            light       = $urandom_range(65535, 1);
            stable      = $urandom_range(65535, 0);
            release_len = $urandom_range(65535, 0);
            ramp        = $urandom_range(1048575, 1);
            hold        = $urandom_range(1048575, 1);
            cycle_len   = $urandom_range(1048575, 2);
            endstop     = $urandom_range(65535, 0);
         end
         apply_settings(light, stable, release_len, ramp, hold, cycle_len, endstop);
         run_random_ticks(200);
      end
   endtask

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_valid              = 1'b0;
      req_now_ms             = '0;
      req_power_mw           = '0;
      req_top_distance_mm    = '0;
      req_bottom_distance_mm = '0;
      csr_valid              = 1'b0;
      csr_index              = CSR_LIGHT_LIMIT;
      csr_data               = '0;
      send_idle_pct          = 0;
      recv_stall_pct         = 0;
      tick_now_ms            = '0;
      tick_step_ms           = (int'(RELEASE_RST) + int'(CYCLE_END_RST)) / 40;
      power_class            = GRID_LIGHT;
      class_left             = 0;
      mismatch_count         = 0;
      ticks_sent             = 0;
      settings_count         = 1;
      light_seen             = 0;
      stable_seen            = 0;
      overload_seen          = 0;
      latch_moves            = 0;

      // Hold reset, then release it away from the sampling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_corners();
      test_reset_settings();
      test_short_cycle();
      test_low_extremes();
      test_high_extremes();
      test_random_settings();

      // Drain and give the block time to show any stray result.
      drain_results();

      $display("Covered %0d ticks under %0d register settings: %0d light, %0d stable,",
               ticks_sent, settings_count, light_seen, stable_seen);
      $display("%0d overload, %0d latch moves, under four idling patterns.",
               overload_seen, latch_moves);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #8_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
